### hw/rtl/lnv_pkg.sv
// ----------------------------------------------------------------------------
// lnv_pkg
// Shared types and constants of the vector layer normalization block.
// ----------------------------------------------------------------------------
package lnv_pkg;

  localparam int DATA_BITS   = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_LEN_DEF = 64;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  // Inverse standard deviation is 2^32 / s, with s >= 256, so it fits 25 bits.
  localparam int INV_W       = 25;
  localparam int INV_NUM_W   = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_FLOOR  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] sample;
    logic                        end_of_vector;
  } lnv_in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] norm_value;
    logic                        final_result;
    logic                        truncated;
  } lnv_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_RD,
    S_VAR_SQ,
    S_VAR_ACC,
    S_VAR_GO,
    S_VAR_WAIT,
    S_SQRT,
    S_INV_GO,
    S_INV_WAIT,
    S_OUT_RD,
    S_OUT_MUL,
    S_OUT_NRM,
    S_OUT_Y,
    S_OUT_EMIT
  } back_state_e;

endpackage

### hw/rtl/lnv_queue.sv
// ----------------------------------------------------------------------------
// lnv_queue
// Small job queue between the sample front end and the compute back end.
// ----------------------------------------------------------------------------
module lnv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rptr_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i && !empty_o) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      cnt_q <= cnt_q + CW'(push_i && !full_o) - CW'(pop_i && !empty_o);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

endmodule

### hw/rtl/lnv_front.sv
// ----------------------------------------------------------------------------
// lnv_front
// Accepts samples, stores them, keeps the running sum and closes vectors.
// ----------------------------------------------------------------------------
module lnv_front #(
  parameter int MAX_LEN = lnv_pkg::MAX_LEN_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  lnv_pkg::lnv_in_t                              in_data_i,
  output logic                                          push_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                  push_n_o,
  output logic signed [lnv_pkg::DATA_BITS+$clog2(MAX_LEN)-1:0] push_sum_o,
  output logic                                          push_trunc_o,
  input  logic                                          queue_full_i,
  input  logic                                          job_done_i,
  input  logic [$clog2(MAX_LEN)-1:0]                    rd_addr_i,
  output logic signed [lnv_pkg::DATA_BITS-1:0]          rd_data_o
);
  import lnv_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = DATA_BITS + AW;

  logic signed [DATA_BITS-1:0] mem_q [MAX_LEN];
  logic [CW-1:0]               count_q, count_inc;
  logic signed [SW-1:0]        sum_q, sum_inc;
  logic                        hold_q;
  logic                        accept, close;

  assign in_ready_o = !hold_q && !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_inc  = count_q + CW'(1);
  assign sum_inc    = sum_q + SW'(in_data_i.sample);
  assign close      = in_data_i.end_of_vector || (count_inc == CW'(MAX_LEN));

  assign push_o       = accept && close;
  assign push_n_o     = count_inc;
  assign push_sum_o   = sum_inc;
  assign push_trunc_o = !in_data_i.end_of_vector;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[count_q[AW-1:0]] <= in_data_i.sample;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

  // The store is shared with the back end, so a closed vector blocks new
  // samples until its last result has entered the back end's output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      hold_q  <= 1'b0;
    end else begin
      if (accept) begin
        if (close) begin
          count_q <= '0;
          sum_q   <= '0;
          hold_q  <= 1'b1;
        end else begin
          count_q <= count_inc;
          sum_q   <= sum_inc;
        end
      end else if (job_done_i) begin
        hold_q <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CW'(MAX_LEN))
    else $error("sample count reached the store depth");

endmodule

### hw/rtl/lnv_div.sv
// ----------------------------------------------------------------------------
// lnv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnv_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int KW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q, rem_sh;
  logic [KW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic             fit;

  assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
      num_q <= {num_q[NUM_W-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= KW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - KW'(1);
        if (cnt_q == KW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/lnv_back.sv
// ----------------------------------------------------------------------------
// lnv_back
// Computes mean, variance, inverse deviation and the normalized results.
// ----------------------------------------------------------------------------
module lnv_back #(
  parameter int MAX_LEN = lnv_pkg::MAX_LEN_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          job_valid_i,
  output logic                                          job_pop_o,
  input  logic [$clog2(MAX_LEN+1)-1:0]                  job_n_i,
  input  logic signed [lnv_pkg::DATA_BITS+$clog2(MAX_LEN)-1:0] job_sum_i,
  input  logic                                          job_trunc_i,
  output logic [$clog2(MAX_LEN)-1:0]                    rd_addr_o,
  input  logic signed [lnv_pkg::DATA_BITS-1:0]          rd_data_i,
  input  logic signed [lnv_pkg::CFG_W-1:0]              gain_i,
  input  logic signed [lnv_pkg::CFG_W-1:0]              offset_i,
  input  logic [lnv_pkg::CFG_W-1:0]                     floor_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output lnv_pkg::lnv_out_t                             out_data_o,
  output logic                                          done_o
);
  import lnv_pkg::*;

  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int AW    = $clog2(MAX_LEN);
  localparam int SW    = DATA_BITS + AW;
  localparam int DW    = DATA_BITS + 1;
  localparam int SQ_W  = 2 * DATA_BITS;
  localparam int DEVW  = SQ_W + CW;
  localparam int VW    = SQ_W + 1;
  localparam int RAD_W = VW + 17;
  localparam int SQW   = RAD_W / 2;
  localparam int RW    = SQW + 2;
  localparam int DIVA  = (DEVW + 1 > INV_NUM_W) ? DEVW + 1 : INV_NUM_W;
  localparam int DIVW  = (DIVA > SW + 1) ? DIVA : SW + 1;
  localparam int DENW  = (CW > SQW) ? CW : SQW;
  localparam int KW    = $clog2(SQW + 1);
  localparam int P1W   = DW + INV_W + 1;
  localparam int NMW   = P1W - 16;
  localparam int P2W   = NMW + 1 + CFG_W;
  localparam int Y1W   = P2W - FRAC_BITS;
  localparam int YW    = Y1W + 2;
  localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (DATA_BITS - 1)) - 1);
  localparam logic signed [YW-1:0] Y_MIN = -YW'(1 << (DATA_BITS - 1));

  back_state_e state_q, state_d;

  logic [CW-1:0]           n_q, idx_q;
  logic signed [SW-1:0]    sum_q;
  logic                    trunc_q;
  logic signed [DW-1:0]    mean_q;
  logic [SQ_W-1:0]         sq_q;
  logic [DEVW-1:0]         dev_q;
  logic [RAD_W-1:0]        rad_q;
  logic [RW-1:0]           rem_q;
  logic [SQW-1:0]          root_q;
  logic [KW-1:0]           sq_cnt_q;
  logic [INV_W-1:0]        inv_q;
  logic signed [P1W-1:0]   p1_q;
  logic signed [P2W-1:0]   p2_q;
  logic signed [DATA_BITS-1:0] y_q;
  logic                    out_valid_q;
  lnv_out_t                out_q;

  logic                    div_start, div_busy, div_done;
  logic [DIVW-1:0]         div_num, div_quot;
  logic [DENW-1:0]         div_den;

  logic                    last_idx, out_free;
  logic signed [DW-1:0]    dev;
  logic [DATA_BITS-1:0]    dev_abs;
  logic [SW-1:0]           sum_abs;
  logic [DW-1:0]           mean_mag;
  logic [VW-1:0]           var_v;
  logic [RW+1:0]           rem2, trial;
  logic [P1W-1:0]          m1;
  logic signed [NMW:0]     nrm;
  logic [P2W-1:0]          m2;
  logic signed [Y1W:0]     y1;
  logic signed [YW-1:0]    y;

  lnv_div #(
    .NUM_W(DIVW),
    .DEN_W(DENW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign last_idx    = (idx_q == n_q - CW'(1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign rd_addr_o   = idx_q[AW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dev      = DW'(rd_data_i) - mean_q;
  assign dev_abs  = dev[DW-1] ? DATA_BITS'(-dev) : DATA_BITS'(dev);
  assign sum_abs  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign mean_mag = div_quot[DW-1:0];
  assign var_v    = VW'(div_quot[SQ_W-1:0]) + VW'(floor_i);
  assign rem2     = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial    = (RW+2)'({root_q, 2'b01});

  // Both rounding steps work on the magnitude so ties go away from zero.
  always_comb begin
    m1  = p1_q[P1W-1] ? P1W'(-p1_q) : P1W'(p1_q);
    nrm = (NMW+1)'((m1 + P1W'(1 << 15)) >> 16);
    if (p1_q[P1W-1]) begin
      nrm = -nrm;
    end
    m2 = p2_q[P2W-1] ? P2W'(-p2_q) : P2W'(p2_q);
    y1 = (Y1W+1)'((m2 + P2W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    if (p2_q[P2W-1]) begin
      y1 = -y1;
    end
    y = YW'(y1) + YW'(offset_i);
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DENW'(n_q);
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = DIVW'(sum_abs) + DIVW'(n_q >> 1);
        state_d   = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: if (div_done) state_d = S_VAR_RD;
      S_VAR_RD:    state_d = S_VAR_SQ;
      S_VAR_SQ:    state_d = S_VAR_ACC;
      S_VAR_ACC:   state_d = last_idx ? S_VAR_GO : S_VAR_RD;
      S_VAR_GO: begin
        div_start = 1'b1;
        div_num   = DIVW'(dev_q) + DIVW'(n_q >> 1);
        state_d   = S_VAR_WAIT;
      end
      S_VAR_WAIT:  if (div_done) state_d = S_SQRT;
      S_SQRT:      if (sq_cnt_q == KW'(1)) state_d = S_INV_GO;
      S_INV_GO: begin
        div_start = 1'b1;
        div_num   = DIVW'({1'b1, 32'b0});
        div_den   = DENW'(root_q);
        state_d   = S_INV_WAIT;
      end
      S_INV_WAIT:  if (div_done) state_d = S_OUT_RD;
      S_OUT_RD:    state_d = S_OUT_MUL;
      S_OUT_MUL:   state_d = S_OUT_NRM;
      S_OUT_NRM:   state_d = S_OUT_Y;
      S_OUT_Y:     state_d = S_OUT_EMIT;
      S_OUT_EMIT: begin
        if (out_free) begin
          if (last_idx) begin
            done_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        n_q     <= job_n_i;
        sum_q   <= job_sum_i;
        trunc_q <= job_trunc_i;
        idx_q   <= '0;
        dev_q   <= '0;
      end
      S_MEAN_WAIT: begin
        mean_q <= sum_q[SW-1] ? -$signed(mean_mag) : $signed(mean_mag);
      end
      S_VAR_SQ:  sq_q <= dev_abs * dev_abs;
      S_VAR_ACC: begin
        dev_q <= dev_q + DEVW'(sq_q);
        idx_q <= last_idx ? '0 : idx_q + CW'(1);
      end
      S_VAR_WAIT: begin
        // A zero spread with a zero floor is taken as the smallest variance.
        rad_q    <= {1'b0, (var_v == '0) ? VW'(1) : var_v, 16'b0};
        rem_q    <= '0;
        root_q   <= '0;
        sq_cnt_q <= KW'(SQW);
      end
      S_SQRT: begin
        if (rem2 >= trial) begin
          rem_q  <= RW'(rem2 - trial);
          root_q <= {root_q[SQW-2:0], 1'b1};
        end else begin
          rem_q  <= RW'(rem2);
          root_q <= {root_q[SQW-2:0], 1'b0};
        end
        rad_q    <= {rad_q[RAD_W-3:0], 2'b00};
        sq_cnt_q <= sq_cnt_q - KW'(1);
      end
      S_INV_WAIT: inv_q <= div_quot[INV_W-1:0];
      S_OUT_MUL:  p1_q  <= dev * $signed({1'b0, inv_q});
      S_OUT_NRM:  p2_q  <= nrm * gain_i;
      S_OUT_Y: begin
        if (y > Y_MAX) begin
          y_q <= DATA_BITS'(Y_MAX);
        end else if (y < Y_MIN) begin
          y_q <= DATA_BITS'(Y_MIN);
        end else begin
          y_q <= DATA_BITS'(y);
        end
      end
      S_OUT_EMIT: begin
        if (out_free) begin
          out_q.norm_value   <= y_q;
          out_q.final_result <= last_idx;
          out_q.truncated    <= trunc_q;
          idx_q              <= idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_MEAN_WAIT || state_q == S_VAR_WAIT ||
                  state_q == S_INV_WAIT))
    else $error("divider finished outside a wait state");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_MEAN_GO) |-> n_q != '0)
    else $error("job with zero length in progress");

endmodule

### hw/rtl/layer_norm_vector.sv
// ----------------------------------------------------------------------------
// layer_norm_vector
// Layer normalization of one vector of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a vector is open and written to an
// internal store. The item marked end_of_vector, or the MAX_LEN-th item,
// closes the vector; input then stays blocked until the last result of that
// vector has entered the output register. For a vector of n samples the back
// end takes the job, makes a variance pass over the samples (read, square,
// accumulate) and a result pass (read, scale by the inverse deviation,
// apply the gain, add the offset and clamp, emit) through the store's
// single read port, with three divisions on the one-bit-per-cycle divider
// and a two-bit-per-cycle square root (DIVW = 40, SQW = 25 by default).
// Configuration writes take effect at once and belong between vectors.
module layer_norm_vector #(
  parameter int MAX_LEN = lnv_pkg::MAX_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lnv_pkg::lnv_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lnv_pkg::lnv_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [lnv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lnv_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import lnv_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = DATA_BITS + AW;
  localparam int JW = CW + SW + 1;

  logic signed [CFG_W-1:0] gain_q, offset_q;
  logic [CFG_W-1:0]        floor_q;

  logic                    push, q_full, q_empty, pop, job_done, push_trunc;
  logic [CW-1:0]           push_n;
  logic signed [SW-1:0]    push_sum;
  logic [JW-1:0]           job;
  logic [AW-1:0]           rd_addr;
  logic signed [DATA_BITS-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= CFG_W'(256);
      offset_q <= '0;
      floor_q  <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:   gain_q   <= cfg_wdata_i;
        CFG_OFFSET: offset_q <= cfg_wdata_i;
        CFG_FLOOR:  floor_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lnv_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_n_o    (push_n),
    .push_sum_o  (push_sum),
    .push_trunc_o(push_trunc),
    .queue_full_i(q_full),
    .job_done_i  (job_done),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  lnv_queue #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_n, push_sum, push_trunc}),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_data_o (job)
  );

  lnv_back #(
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .job_pop_o  (pop),
    .job_n_i    (job[JW-1 -: CW]),
    .job_sum_i  ($signed(job[SW:1])),
    .job_trunc_i(job[0]),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .gain_i     (gain_q),
    .offset_i   (offset_q),
    .floor_i    (floor_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .done_o     (job_done)
  );

endmodule
